// ===== sv/mrf_pkg.sv =====
// ============================================================================
// mrf_pkg
// Shared constants, job descriptor and CRC helper for the request framer.
// ============================================================================
`default_nettype none

package mrf_pkg;

    // default limits on element counts
    localparam int MAX_REGISTER_COUNT_DEF = 123;
    localparam int MAX_COIL_COUNT_DEF     = 1968;

    // job queue depth and largest number of plain bytes in one job
    localparam int QUEUE_DEPTH = 4;
    localparam int JOB_BYTES   = 7;

    // item kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // supported function codes
    localparam logic [7:0] FC_READ_COILS    = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT    = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
    localparam logic [7:0] FC_WRITE_REG     = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS   = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS    = 8'h10;

    // crc and coil encoding
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    localparam logic [7:0] SLAVE_ID_RESET = 8'd3;

    // one unit of work for the back end
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic                      crc_init;
        logic                      crc_tail;
        logic                      err;
    } job_t;

    // one byte through the reflected crc-16
    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mrf_if.sv =====
// ============================================================================
// mrf_if
// Handshake channels of the request framer: request, frame and config.
// ============================================================================
`default_nettype none

interface mrf_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  fn_code;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic [15:0] data_word;

    modport source (output valid, cmd, fn_code, start_address, quantity_or_value,
                    data_word, input ready);
    modport sink   (input valid, cmd, fn_code, start_address, quantity_or_value,
                    data_word, output ready);
endinterface

interface mrf_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       error;

    modport source (output valid, frame_byte, last_byte, error, input ready);
    modport sink   (input valid, frame_byte, last_byte, error, output ready);
endinterface

interface mrf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/mrf_fifo.sv =====
// ============================================================================
// mrf_fifo
// Short register queue of job descriptors between front and back end.
// ============================================================================
`default_nettype none

module mrf_fifo #(
    parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mrf_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output mrf_pkg::job_t      pop_job,
    output logic               pop_valid
);
    import mrf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    // flags
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue count beyond depth");

endmodule

`default_nettype wire

// ===== sv/mrf_front.sv =====
// ============================================================================
// mrf_front
// Takes request words, checks them, tracks the open multiple write and
// turns each word into a job descriptor for the byte sequencer.
// ============================================================================
`default_nettype none

module mrf_front #(
    parameter int MAX_REGISTER_COUNT = mrf_pkg::MAX_REGISTER_COUNT_DEF,
    parameter int MAX_COIL_COUNT     = mrf_pkg::MAX_COIL_COUNT_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    mrf_req_if.sink        req,
    mrf_cfg_if.sink        cfg,
    output logic           push,
    output mrf_pkg::job_t  push_job,
    input  wire logic      queue_full
);
    import mrf_pkg::*;

    localparam logic [15:0] REG_LIMIT  = 16'(MAX_REGISTER_COUNT);
    localparam logic [15:0] COIL_LIMIT = 16'(MAX_COIL_COUNT);

    logic [7:0]  slave_id_reg;
    logic        open_reg, open_next;
    logic        wr_regs_reg, wr_regs_next;
    logic [10:0] rem_reg, rem_next;
    logic [7:0]  pack_reg, pack_next;
    logic [2:0]  pos_reg, pos_next;

    logic        accept;
    logic        job_fire;
    job_t        job;
    logic        is_coil_q, is_reg_q, is_single, is_multi, ok;
    logic [15:0] qv, v;
    logic [16:0] qv_plus;
    logic [7:0]  bc;
    logic [10:0] rem_dec;
    logic [7:0]  pack_set;
    logic [2:0]  pos_inc;

    // handshakes
    assign cfg.ready = 1'b1;
    assign req.ready = !queue_full;
    assign accept    = req.valid && req.ready;
    assign push      = accept && job_fire;
    assign push_job  = job;

    // classification
    assign qv        = req.quantity_or_value;
    assign is_coil_q = (req.fn_code == FC_READ_COILS)
                    || (req.fn_code == FC_READ_DISCRETE)
                    || (req.fn_code == FC_WRITE_COILS);
    assign is_reg_q  = (req.fn_code == FC_READ_HOLDING)
                    || (req.fn_code == FC_READ_INPUT)
                    || (req.fn_code == FC_WRITE_REGS);
    assign is_single = (req.fn_code == FC_WRITE_COIL)
                    || (req.fn_code == FC_WRITE_REG);
    assign is_multi  = (req.fn_code == FC_WRITE_COILS)
                    || (req.fn_code == FC_WRITE_REGS);
    assign ok = is_single
             || (is_coil_q && (qv != 16'd0) && (qv <= COIL_LIMIT))
             || (is_reg_q && (qv != 16'd0) && (qv <= REG_LIMIT));

    // value field and byte count
    assign v       = (req.fn_code == FC_WRITE_COIL)
                   ? ((qv != 16'd0) ? COIL_ON : COIL_OFF) : qv;
    assign qv_plus = {1'b0, qv} + 17'd7;
    assign bc      = (req.fn_code == FC_WRITE_REGS) ? {qv[6:0], 1'b0} : qv_plus[10:3];

    // element bookkeeping
    assign rem_dec  = rem_reg - 11'd1;
    assign pos_inc  = pos_reg + 3'd1;

    always_comb
    begin
        pack_set          = pack_reg;
        pack_set[pos_reg] = pack_reg[pos_reg] | req.data_word[0];
    end

    // job build and next state
    always_comb
    begin
        job          = '0;
        open_next    = open_reg;
        wr_regs_next = wr_regs_reg;
        rem_next     = rem_reg;
        pack_next    = pack_reg;
        pos_next     = pos_reg;
        if (req.cmd == CMD_START)
        begin
            open_next = 1'b0;
            pack_next = '0;
            pos_next  = '0;
            if (!ok)
            begin
                job.err = 1'b1;
            end
            else
            begin
                job.bytes[0] = slave_id_reg;
                job.bytes[1] = req.fn_code;
                job.bytes[2] = req.start_address[15:8];
                job.bytes[3] = req.start_address[7:0];
                job.bytes[4] = v[15:8];
                job.bytes[5] = v[7:0];
                job.crc_init = 1'b1;
                if (is_multi)
                begin
                    job.bytes[6] = bc;
                    job.nbytes   = 3'd7;
                    open_next    = 1'b1;
                    wr_regs_next = (req.fn_code == FC_WRITE_REGS);
                    rem_next     = qv[10:0];
                end
                else
                begin
                    job.nbytes   = 3'd6;
                    job.crc_tail = 1'b1;
                end
            end
        end
        else if (!open_reg)
        begin
            job.err = 1'b1;
        end
        else
        begin
            rem_next = rem_dec;
            if (wr_regs_reg)
            begin
                job.bytes[0] = req.data_word[15:8];
                job.bytes[1] = req.data_word[7:0];
                job.nbytes   = 3'd2;
            end
            else if ((pos_inc == 3'd0) || (rem_dec == 11'd0))
            begin
                job.bytes[0] = pack_set;
                job.nbytes   = 3'd1;
                pack_next    = '0;
                pos_next     = '0;
            end
            else
            begin
                pack_next = pack_set;
                pos_next  = pos_inc;
            end
            if (rem_dec == 11'd0)
            begin
                job.crc_tail = 1'b1;
                open_next    = 1'b0;
            end
        end
        job_fire = job.err || (job.nbytes != 3'd0) || job.crc_tail;
    end

    // request state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_id_reg <= SLAVE_ID_RESET;
            open_reg     <= 1'b0;
            wr_regs_reg  <= 1'b0;
            rem_reg      <= '0;
            pack_reg     <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                slave_id_reg <= cfg.data;
            end
            if (accept)
            begin
                open_reg    <= open_next;
                wr_regs_reg <= wr_regs_next;
                rem_reg     <= rem_next;
                pack_reg    <= pack_next;
                pos_reg     <= pos_next;
            end
        end
    end

    // an open request always has elements still to come
    a_open_has_elements: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (rem_reg != 11'd0))
        else $error("open request with no elements left");

endmodule

`default_nettype wire

// ===== sv/mrf_back.sv =====
// ============================================================================
// mrf_back
// Byte sequencer: plays out one job at a time through the output register,
// running the crc over data bytes and appending it where the job asks.
// ============================================================================
`default_nettype none

module mrf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mrf_pkg::job_t pop_job,
    input  wire logic          pop_valid,
    output logic               pop,
    mrf_frm_if.source          frm
);
    import mrf_pkg::*;

    job_t        job_reg;
    logic        job_valid_reg;
    logic [3:0]  step_reg;
    logic [15:0] crc_reg, crc_next;
    logic        frm_valid_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        err_reg, err_next;

    logic        can_emit;
    logic        final_elem;
    logic        crc_upd;
    logic [15:0] crc_base;
    logic [3:0]  nb4;

    assign frm.valid      = frm_valid_reg;
    assign frm.frame_byte = byte_reg;
    assign frm.last_byte  = last_reg;
    assign frm.error      = err_reg;

    assign can_emit = job_valid_reg && (!frm_valid_reg || frm.ready);
    assign nb4      = {1'b0, job_reg.nbytes};
    assign pop      = pop_valid && (!job_valid_reg || (can_emit && final_elem));
    assign crc_base = (job_reg.crc_init && (step_reg == 4'd0)) ? CRC_INIT : crc_reg;

    // pick the element for this step
    always_comb
    begin
        byte_next  = 8'h00;
        last_next  = 1'b0;
        err_next   = 1'b0;
        final_elem = 1'b0;
        crc_upd    = 1'b0;
        crc_next   = crc_reg;
        if (job_reg.err)
        begin
            last_next  = 1'b1;
            err_next   = 1'b1;
            final_elem = 1'b1;
        end
        else if (step_reg < nb4)
        begin
            byte_next  = job_reg.bytes[step_reg[2:0]];
            crc_next   = crc_feed(crc_base, byte_next);
            crc_upd    = 1'b1;
            final_elem = ((step_reg + 4'd1) == nb4) && !job_reg.crc_tail;
        end
        else if (step_reg == nb4)
        begin
            byte_next = crc_reg[7:0];
        end
        else
        begin
            byte_next  = crc_reg[15:8];
            last_next  = 1'b1;
            final_elem = 1'b1;
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= '0;
            crc_reg       <= CRC_INIT;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                job_valid_reg <= 1'b1;
                step_reg      <= '0;
            end
            else if (can_emit && final_elem)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (can_emit)
            begin
                step_reg <= step_reg + 4'd1;
            end
            if (can_emit && crc_upd)
            begin
                crc_reg <= crc_next;
            end
            if (can_emit)
            begin
                frm_valid_reg <= 1'b1;
            end
            else if (frm.ready)
            begin
                frm_valid_reg <= 1'b0;
            end
        end
    end

    // job and word payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_job;
        end
        if (can_emit)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    // an error word always closes its frame
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frm_valid_reg && err_reg) |-> last_reg)
        else $error("error word without last flag");

    // the step never runs past the crc bytes of the job
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && !job_reg.err) |-> (step_reg <= nb4 + 4'd1))
        else $error("sequencer step past end of job");

    // a job is only fetched when the current one is done or absent
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && job_valid_reg) |-> (can_emit && final_elem))
        else $error("job fetched while current job unfinished");

endmodule

`default_nettype wire

// ===== sv/modbus_rtu_request_framer_unit.sv =====
// Modbus RTU request framer. Each request word becomes a run of frame words,
// one byte per ready cycle from a registered output: a read or single write
// start gives eight words (slave id, function, address, value or quantity, CRC
// low and high), a multiple write start gives seven and leaves the request
// open, a register data word gives two (four with the closing CRC) and a coil
// data word gives none, one or three. An invalid word gives one error
// word. The output byte rate of the sequencer sets the throughput; the front
// end keeps accepting request words while the four-entry job queue has room,
// so input stalls only once the queue is full behind a slow or stalled sink.
// ============================================================================
// modbus_rtu_request_framer_unit
// Top level: front end, job queue and byte sequencer.
// ============================================================================
`default_nettype none

module modbus_rtu_request_framer_unit #(
    parameter int MAX_REGISTER_COUNT = mrf_pkg::MAX_REGISTER_COUNT_DEF,
    parameter int MAX_COIL_COUNT     = mrf_pkg::MAX_COIL_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mrf_cfg_if.sink    cfg,
    mrf_req_if.sink    req,
    mrf_frm_if.source  frm
);
    import mrf_pkg::*;

    job_t push_job;
    job_t pop_job;
    logic push;
    logic pop;
    logic queue_full;
    logic pop_valid;

    // request decode
    mrf_front #(
        .MAX_REGISTER_COUNT (MAX_REGISTER_COUNT),
        .MAX_COIL_COUNT     (MAX_COIL_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    // job queue
    mrf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_job   (pop_job),
        .pop_valid (pop_valid)
    );

    // byte sequencer
    mrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_job   (pop_job),
        .pop_valid (pop_valid),
        .pop       (pop),
        .frm       (frm)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the Modbus RTU request framer against a built-in frame predictor.
// Request words go in through a sender task with random gaps, and the frame
// sink stalls at random. Every accepted frame word is compared field by field
// with the oldest predicted word. Directed tests come first: read and single
// write codes, rejected words, multiple writes, abandoned requests and the
// largest counts. Random traffic with several slave ids follows.
// ============================================================================

module testbench;

    import mrf_pkg::*;

    // one predicted word on the frame channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } frame_word_t;

    localparam int HOLD_OFF = 40;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   fail_count;
    int   hold_cycles;

    frame_word_t frame_words_due[$];
    frame_word_t due_word;

    // predictor state
    logic [7:0]  m_slave_id  = SLAVE_ID_RESET;
    logic [15:0] m_crc       = CRC_INIT;
    logic [10:0] m_left      = '0;
    logic [7:0]  m_coil_byte = '0;
    logic [2:0]  m_coil_pos  = '0;
    logic        m_open      = 1'b0;
    logic        m_regs      = 1'b0;

    mrf_req_if req ();
    mrf_frm_if frm ();
    mrf_cfg_if cfg ();

    modbus_rtu_request_framer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .frm   (frm)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // modbus crc-16, lsb first with reflected polynomial
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = c;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ b[i];
            acc = {1'b0, acc[15:1]};
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // -1 unsupported, 0 single write (no count), else the largest count
    function automatic int count_limit(input logic [7:0] fc);
        case (fc)
            FC_READ_COILS, FC_READ_DISCRETE, FC_WRITE_COILS: return MAX_COIL_COUNT_DEF;
            FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_REGS:   return MAX_REGISTER_COUNT_DEF;
            FC_WRITE_COIL, FC_WRITE_REG:                     return 0;
            default:                                         return -1;
        endcase
    endfunction

    function automatic void push_word(input logic [7:0] b, input logic last, input logic err);
        frame_word_t w;
        w.data = b;
        w.last = last;
        w.err  = err;
        frame_words_due.push_back(w);
    endfunction

    function automatic void push_data(input logic [7:0] b);
        m_crc = crc16_byte(m_crc, b);
        push_word(b, 1'b0, 1'b0);
    endfunction

    function automatic void push_crc();
        push_word(m_crc[7:0], 1'b0, 1'b0);
        push_word(m_crc[15:8], 1'b1, 1'b0);
        m_open = 1'b0;
    endfunction

    // frame words caused by one accepted request word
    function automatic void build_expected_frame(input logic cmd, input logic [7:0] fc,
                                                 input logic [15:0] addr, input logic [15:0] qv,
                                                 input logic [15:0] dw);
        int          lim;
        logic [15:0] val;
        if (cmd == CMD_START)
        begin
            // a start drops any open multiple write
            m_open      = 1'b0;
            m_coil_byte = '0;
            m_coil_pos  = '0;
            lim = count_limit(fc);
            if (lim < 0 || (lim > 0 && (qv == 16'd0 || qv > lim)))
            begin
                push_word(8'h00, 1'b1, 1'b1);
                return;
            end
            m_crc = CRC_INIT;
            push_data(m_slave_id);
            push_data(fc);
            push_data(addr[15:8]);
            push_data(addr[7:0]);
            if (fc == FC_WRITE_COIL)
                val = (qv != 16'd0) ? COIL_ON : COIL_OFF;
            else
                val = qv;
            push_data(val[15:8]);
            push_data(val[7:0]);
            if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS)
            begin
                if (fc == FC_WRITE_REGS)
                    push_data(8'(qv * 2));
                else
                    push_data(8'((qv + 7) / 8));
                m_open = 1'b1;
                m_regs = (fc == FC_WRITE_REGS);
                m_left = qv[10:0];
            end
            else
            begin
                push_crc();
            end
        end
        else if (!m_open)
        begin
            push_word(8'h00, 1'b1, 1'b1);
        end
        else if (m_regs)
        begin
            push_data(dw[15:8]);
            push_data(dw[7:0]);
            m_left = m_left - 1'b1;
            if (m_left == 0)
                push_crc();
        end
        else
        begin
            // coils pack lsb first, a byte goes out when full or on the last coil
            if (dw[0])
                m_coil_byte[m_coil_pos] = 1'b1;
            m_coil_pos = m_coil_pos + 1'b1;
            m_left     = m_left - 1'b1;
            if (m_coil_pos == 0 || m_left == 0)
            begin
                push_data(m_coil_byte);
                m_coil_byte = '0;
                m_coil_pos  = '0;
            end
            if (m_left == 0)
                push_crc();
        end
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // with_count: codes that carry a quantity, else reads and single writes
    function automatic logic [7:0] pick_code(input bit with_count);
        case ($urandom_range(0, 5))
            0:       return FC_READ_COILS;
            1:       return FC_READ_DISCRETE;
            2:       return FC_READ_HOLDING;
            3:       return FC_READ_INPUT;
            4:       return with_count ? FC_WRITE_COILS : FC_WRITE_COIL;
            default: return with_count ? FC_WRITE_REGS : FC_WRITE_REG;
        endcase
    endfunction

    // frame sink with random stall bursts
    initial
    begin
        frm.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                frm.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                hold_cycles = $urandom_range(1, 16) - 1;
                frm.ready <= 1'b0;
            end
            else
            begin
                frm.ready <= 1'b1;
            end
        end
    end

    // compare each accepted frame word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && frm.valid === 1'b1 && frm.ready === 1'b1)
        begin
            if (frame_words_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %02h last %b error %b",
                                          frm.frame_byte, frm.last_byte, frm.error));
            end
            else
            begin
                due_word = frame_words_due.pop_front();
                if (frm.frame_byte !== due_word.data)
                    report_mismatch($sformatf("frame_byte got %02h want %02h",
                                              frm.frame_byte, due_word.data));
                if (frm.last_byte !== due_word.last)
                    report_mismatch($sformatf("last_byte got %b want %b (byte %02h)",
                                              frm.last_byte, due_word.last, due_word.data));
                if (frm.error !== due_word.err)
                    report_mismatch($sformatf("error got %b want %b (byte %02h)",
                                              frm.error, due_word.err, due_word.data));
            end
        end
    end

    // send one request word, predict its frame words once accepted
    task automatic send_item(input logic cmd, input logic [7:0] fc, input logic [15:0] addr,
                             input logic [15:0] qv, input logic [15:0] dw);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid             <= 1'b1;
        req.cmd               <= cmd;
        req.fn_code           <= fc;
        req.start_address     <= addr;
        req.quantity_or_value <= qv;
        req.data_word         <= dw;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        build_expected_frame(cmd, fc, addr, qv, dw);
    endtask

    task automatic send_start(input logic [7:0] fc, input logic [15:0] addr,
                              input logic [15:0] qv);
        send_item(CMD_START, fc, addr, qv, rand16());
    endtask

    task automatic send_data(input logic [15:0] dw);
        send_item(CMD_DATA, 8'($urandom_range(0, 255)), rand16(), rand16(), dw);
    endtask

    // stop sending and let every predicted word arrive, then let the block settle
    task automatic wait_frames_done();
        req.valid <= 1'b0;
        while (frame_words_due.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic change_slave_id(input logic [7:0] id);
        wait_frames_done();
        cfg.valid <= 1'b1;
        cfg.data  <= id;
        @(posedge clk);
        while (cfg.ready !== 1'b1)
            @(posedge clk);
        m_slave_id = id;
        cfg.valid <= 1'b0;
    endtask

    // reads and single writes at the field extremes
    task automatic test_read_and_single();
        send_start(FC_READ_COILS, 16'h0000, 16'd1);
        send_start(FC_READ_DISCRETE, 16'hFFFF, 16'(MAX_COIL_COUNT_DEF));
        send_start(FC_READ_HOLDING, 16'h1234, 16'(MAX_REGISTER_COUNT_DEF));
        send_start(FC_READ_INPUT, 16'hA5C3, 16'd1);
        send_start(FC_WRITE_COIL, 16'h00FF, 16'h0000);
        send_start(FC_WRITE_COIL, 16'hFF00, 16'h8000);
        send_start(FC_WRITE_REG, 16'hFFFF, 16'hFFFF);
        send_start(FC_WRITE_REG, 16'h0000, 16'h0000);
    endtask

    // unknown codes, counts out of range and stray data
    task automatic test_rejects();
        send_start(8'h00, rand16(), 16'd1);
        send_start(8'h07, rand16(), 16'd1);
        send_start(8'hFF, rand16(), 16'd1);
        send_start(FC_READ_COILS, rand16(), 16'd0);
        send_start(FC_WRITE_COILS, rand16(), 16'(MAX_COIL_COUNT_DEF + 1));
        send_start(FC_READ_INPUT, rand16(), 16'(MAX_REGISTER_COUNT_DEF + 1));
        send_start(FC_WRITE_REGS, rand16(), 16'hFFFF);
        send_data(16'hFFFF);
    endtask

    // short register and coil writes, coils running past one byte
    task automatic test_multiple_writes();
        send_start(FC_WRITE_REGS, 16'h0010, 16'd2);
        send_data(16'hFFFF);
        send_data(16'h0000);
        send_start(FC_WRITE_COILS, 16'h0013, 16'd9);
        for (int i = 0; i < 9; i++)
            send_data(16'(((i % 3) == 0) ? 16'h0001 : 16'hFFFE));
    endtask

    // a start in the middle of an open write drops it
    task automatic test_abandoned_request();
        send_start(FC_WRITE_REGS, 16'h0100, 16'd3);
        send_data(16'hBEEF);
        send_start(FC_READ_INPUT, 16'hFFFF, 16'd7);
        send_start(FC_WRITE_COILS, 16'h0000, 16'(MAX_COIL_COUNT_DEF));
        send_data(16'h0001);
        send_data(16'h0001);
        send_data(16'h0001);
        send_start(FC_READ_COILS, 16'h0001, 16'd3);
    endtask

    task automatic test_register_limit();
        send_start(FC_WRITE_REGS, rand16(), 16'(MAX_REGISTER_COUNT_DEF));
        repeat (MAX_REGISTER_COUNT_DEF) send_data(rand16());
    endtask

    // largest coil count: top byte count, a few coils, then closed by a read
    task automatic test_coil_limit();
        send_start(FC_WRITE_COILS, rand16(), 16'(MAX_COIL_COUNT_DEF));
        repeat (10) send_data(rand16());
        send_start(FC_READ_HOLDING, rand16(), 16'd1);
    endtask

    // mostly whole requests with random content, the rest noise
    task automatic test_random_traffic(input int budget);
        int          sent;
        int          pick;
        int          lim;
        int          qty;
        int          upto;
        logic [7:0]  fc;
        logic [15:0] qv;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // multiple write, now and then cut short by the next start
                fc  = $urandom_range(0, 1) ? FC_WRITE_REGS : FC_WRITE_COILS;
                lim = count_limit(fc);
                if ($urandom_range(0, 7) == 0)
                    qty = $urandom_range(1, (fc == FC_WRITE_REGS) ? lim : 80);
                else
                    qty = $urandom_range(1, 20);
                upto = ($urandom_range(0, 9) == 0) ? $urandom_range(0, qty - 1) : qty;
                if (upto > budget - sent - 1)
                    upto = budget - sent - 1;
                send_start(fc, rand16(), 16'(qty));
                repeat (upto) send_data(rand16());
                sent += 1 + upto;
            end
            else if (pick < 80)
            begin
                fc  = pick_code(1'b0);
                lim = count_limit(fc);
                if (lim == 0)
                    qv = ($urandom_range(0, 7) == 0) ? 16'h0000 : rand16();
                else
                    qv = ($urandom_range(0, 3) == 0) ? 16'(lim) : 16'($urandom_range(1, lim));
                send_start(fc, rand16(), qv);
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        send_data(rand16());
                    end
                    1:
                    begin
                        do
                            fc = 8'($urandom_range(0, 255));
                        while (count_limit(fc) >= 0);
                        send_start(fc, rand16(), rand16());
                    end
                    default:
                    begin
                        fc  = pick_code(1'b1);
                        lim = count_limit(fc);
                        if ($urandom_range(0, 1))
                            qv = 16'h0000;
                        else
                            qv = 16'($urandom_range(lim + 1, 16'hFFFF));
                        send_start(fc, rand16(), qv);
                    end
                endcase
                sent++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        fail_count            = 0;
        hold_cycles           = 0;
        idle_on               = 1'b1;
        rst_n                 = 1'b0;
        req.valid             <= 1'b0;
        req.cmd               <= CMD_START;
        req.fn_code           <= 8'h00;
        req.start_address     <= 16'h0000;
        req.quantity_or_value <= 16'h0000;
        req.data_word         <= 16'h0000;
        cfg.valid             <= 1'b0;
        cfg.data              <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_read_and_single();
        change_slave_id(8'h00);
        test_rejects();
        test_multiple_writes();
        change_slave_id(8'hFF);
        test_abandoned_request();
        test_register_limit();
        test_coil_limit();
        change_slave_id(8'($urandom_range(1, 254)));
        test_random_traffic(25);
        change_slave_id(8'($urandom_range(1, 254)));
        test_random_traffic(10);
        // last part runs flat out on both sides
        idle_on = 1'b0;
        change_slave_id(8'($urandom_range(0, 255)));
        test_random_traffic(15);
        wait_frames_done();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
